[src/assert_macros.svh]
// Assertion macros used by the port-level checker of the arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable and a caller-supplied message.
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with a fixed message for short properties.
`define CAU_ASSERT_PLAIN(lbl, clk, rst_n, prop) \
  `CAU_ASSERT(lbl, clk, rst_n, prop, "arithmetic unit check failed")

`endif

[src/cau_pkg.sv]
// Package with opcode codes, decoded instruction types and queue sizing.
`timescale 1ns / 1ps

package cau_pkg;

  // Instruction opcodes as they arrive on the input channel.
  typedef enum logic [3:0] {
    OP_ACI = 4'd0,
    OP_ADC = 4'd1,
    OP_ADD = 4'd2,
    OP_ADI = 4'd3,
    OP_DAA = 4'd4,
    OP_DAD = 4'd5,
    OP_DCR = 4'd6,
    OP_DCX = 4'd7,
    OP_INR = 4'd8,
    OP_INX = 4'd9,
    OP_SBB = 4'd10,
    OP_SBI = 4'd11,
    OP_SUB = 4'd12,
    OP_SUI = 4'd13
  } op_e;

  // Execution classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ARITH,
    CLS_DAA,
    CLS_STEP8,
    CLS_STEP16,
    CLS_DAD
  } cls_e;

  // Operand selector codes.
  localparam logic [2:0] SEL_B = 3'd0;
  localparam logic [2:0] SEL_C = 3'd1;
  localparam logic [2:0] SEL_D = 3'd2;
  localparam logic [2:0] SEL_E = 3'd3;
  localparam logic [2:0] SEL_H = 3'd4;
  localparam logic [2:0] SEL_L = 3'd5;
  localparam logic [2:0] SEL_M = 3'd6;
  localparam logic [2:0] SEL_A = 3'd7;

  // Pair selector codes (selector bits 2:1).
  localparam logic [1:0] PAIR_BC   = 2'd0;
  localparam logic [1:0] PAIR_DE   = 2'd1;
  localparam logic [1:0] PAIR_HL   = 2'd2;
  localparam logic [1:0] PAIR_NONE = 2'd3;

  // Depth of the queue between front and back end.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One decoded instruction as it travels through the queue.
  typedef struct packed {
    cls_e        cls;
    logic        sub;        // subtract for arithmetic, decrement for steps
    logic        use_carry;  // carry or borrow input from the flag
    logic        use_imm;    // second operand is the immediate byte
    logic [2:0]  sel;
    logic [7:0]  imm;
    logic [7:0]  mem;
  } uop_t;

endpackage

[src/cau_if.sv]
// Channel interfaces for instruction beats and result beats.
`timescale 1ns / 1ps

interface cau_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] operand_select;
  logic [7:0] immediate;
  logic [7:0] memory_data;

  modport source (output valid, opcode, operand_select, immediate, memory_data, input ready);
  modport sink (input valid, opcode, operand_select, immediate, memory_data, output ready);
endinterface

interface cau_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_value;
  logic [15:0] pair_value;
  logic [15:0] memory_address;
  logic        memory_write;
  logic        carry_out;
  logic        aux_carry_out;
  logic        sign_out;
  logic        zero_out;
  logic        parity_out;
  logic [15:0] program_counter_out;

  modport source (output valid, result_value, pair_value, memory_address, memory_write,
                  carry_out, aux_carry_out, sign_out, zero_out, parity_out,
                  program_counter_out, input ready);
  modport sink (input valid, result_value, pair_value, memory_address, memory_write,
                carry_out, aux_carry_out, sign_out, zero_out, parity_out,
                program_counter_out, output ready);
endinterface

[src/cau_decode.sv]
// Front end: accepts instruction beats and classifies them for execution.
`timescale 1ns / 1ps

module cau_decode (
  cau_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output cau_pkg::uop_t push_uop_o
);
  import cau_pkg::*;

  // Beats pass straight into the queue when it has room.
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  // Opcode classification.
  always_comb begin
    push_uop_o           = '0;
    push_uop_o.cls       = CLS_NONE;
    push_uop_o.sel       = in_i.operand_select;
    push_uop_o.imm       = in_i.immediate;
    push_uop_o.mem       = in_i.memory_data;
    case (op_e'(in_i.opcode))
      OP_ACI: begin
        push_uop_o.cls       = CLS_ARITH;
        push_uop_o.use_carry = 1'b1;
        push_uop_o.use_imm   = 1'b1;
      end
      OP_ADC: begin
        push_uop_o.cls       = CLS_ARITH;
        push_uop_o.use_carry = 1'b1;
      end
      OP_ADD: push_uop_o.cls = CLS_ARITH;
      OP_ADI: begin
        push_uop_o.cls     = CLS_ARITH;
        push_uop_o.use_imm = 1'b1;
      end
      OP_DAA: push_uop_o.cls = CLS_DAA;
      OP_DAD: push_uop_o.cls = CLS_DAD;
      OP_DCR: begin
        push_uop_o.cls = CLS_STEP8;
        push_uop_o.sub = 1'b1;
      end
      OP_DCX: begin
        push_uop_o.cls = CLS_STEP16;
        push_uop_o.sub = 1'b1;
      end
      OP_INR: push_uop_o.cls = CLS_STEP8;
      OP_INX: push_uop_o.cls = CLS_STEP16;
      OP_SBB: begin
        push_uop_o.cls       = CLS_ARITH;
        push_uop_o.sub       = 1'b1;
        push_uop_o.use_carry = 1'b1;
      end
      OP_SBI: begin
        push_uop_o.cls       = CLS_ARITH;
        push_uop_o.sub       = 1'b1;
        push_uop_o.use_carry = 1'b1;
        push_uop_o.use_imm   = 1'b1;
      end
      OP_SUB: begin
        push_uop_o.cls = CLS_ARITH;
        push_uop_o.sub = 1'b1;
      end
      OP_SUI: begin
        push_uop_o.cls     = CLS_ARITH;
        push_uop_o.sub     = 1'b1;
        push_uop_o.use_imm = 1'b1;
      end
      default: push_uop_o.cls = CLS_NONE;
    endcase
  end

endmodule

[src/cau_queue.sv]
// Short queue of decoded instructions between front and back end.
`timescale 1ns / 1ps

module cau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cau_pkg::uop_t push_uop_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cau_pkg::uop_t pop_uop_o
);
  import cau_pkg::*;

  uop_t             store_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_uop_o    = store_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + QCntW'(1);
      2'b01:   count_d = count_q - QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_uop_i;
    end
  end

endmodule

[src/cau_execute.sv]
// Back end: register file, flags, program counter and the result register.
`timescale 1ns / 1ps

module cau_execute (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          uop_valid_i,
  output logic          uop_ready_o,
  input  cau_pkg::uop_t uop_i,
  cau_out_if.source     out_o
);
  import cau_pkg::*;

  // Architectural state.
  logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q, a_q;
  logic [7:0]  b_d, c_d, d_d, e_d, h_d, l_d, a_d;
  logic        cy_q, ac_q, s_q, z_q, p_q;
  logic        cy_d, ac_d, s_d, z_d, p_d;
  logic [15:0] pc_q, pc_d;

  // Result register.
  logic        valid_q;
  logic [7:0]  res_q, res_d;
  logic [15:0] pair_q, pair_d;
  logic [15:0] addr_q;
  logic        mw_q, mw_d;

  logic        fire;
  logic [7:0]  src8, opnd, addend;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  nib5;
  logic [8:0]  daa_v;
  logic [15:0] hl, cur16;
  logic [16:0] sum17;
  logic        set_szp;

  assign uop_ready_o = !valid_q || out_o.ready;
  assign fire        = uop_valid_i && uop_ready_o;
  assign hl          = {h_q, l_q};

  // Operand fetch for the 8-bit and the pair paths.
  always_comb begin
    case (uop_i.sel)
      SEL_B:   src8 = b_q;
      SEL_C:   src8 = c_q;
      SEL_D:   src8 = d_q;
      SEL_E:   src8 = e_q;
      SEL_H:   src8 = h_q;
      SEL_L:   src8 = l_q;
      SEL_M:   src8 = uop_i.mem;
      default: src8 = a_q;
    endcase
    case (uop_i.sel[2:1])
      PAIR_BC: cur16 = {b_q, c_q};
      PAIR_DE: cur16 = {d_q, e_q};
      PAIR_HL: cur16 = {h_q, l_q};
      default: cur16 = '0;
    endcase
  end

  // Shared 8-bit adder; subtraction adds the inverted operand.
  always_comb begin
    opnd   = uop_i.use_imm ? uop_i.imm : src8;
    addend = uop_i.sub ? ~opnd : opnd;
    if (uop_i.sub) begin
      cin = uop_i.use_carry ? ~cy_q : 1'b1;
    end else begin
      cin = uop_i.use_carry ? cy_q : 1'b0;
    end
    sum9  = {1'b0, a_q} + {1'b0, addend} + {8'd0, cin};
    nib5  = {1'b0, a_q[3:0]} + {1'b0, addend[3:0]} + {4'd0, cin};
    sum17 = {1'b0, hl} + {1'b0, cur16};
  end

  // Next state of registers, flags and the result fields.
  always_comb begin
    b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q; a_d = a_q;
    cy_d    = cy_q;
    ac_d    = ac_q;
    res_d   = '0;
    pair_d  = '0;
    mw_d    = 1'b0;
    daa_v   = {1'b0, a_q};
    set_szp = 1'b0;
    pc_d    = pc_q + 16'd1;
    case (uop_i.cls)
      CLS_ARITH: begin
        res_d   = sum9[7:0];
        cy_d    = sum9[8] ^ uop_i.sub;
        ac_d    = nib5[4];
        a_d     = sum9[7:0];
        set_szp = 1'b1;
      end
      CLS_DAA: begin
        // Low nibble adjust, then high nibble adjust.
        if ((a_q[3:0] > 4'd9) || ac_q) begin
          ac_d  = (a_q[3:0] > 4'd9);
          daa_v = {1'b0, a_q} + 9'h006;
        end else begin
          ac_d = 1'b0;
        end
        if ((daa_v > 9'h09F) || cy_q) begin
          cy_d  = 1'b1;
          res_d = daa_v[7:0] + 8'h60;
        end else begin
          cy_d  = 1'b0;
          res_d = daa_v[7:0];
        end
        a_d     = res_d;
        set_szp = 1'b1;
      end
      CLS_STEP8: begin
        if (uop_i.sub) begin
          res_d = src8 - 8'd1;
          ac_d  = (res_d[3:0] != 4'hF);
        end else begin
          res_d = src8 + 8'd1;
          ac_d  = (res_d[3:0] == 4'h0);
        end
        set_szp = 1'b1;
        case (uop_i.sel)
          SEL_B:   b_d = res_d;
          SEL_C:   c_d = res_d;
          SEL_D:   d_d = res_d;
          SEL_E:   e_d = res_d;
          SEL_H:   h_d = res_d;
          SEL_L:   l_d = res_d;
          SEL_M:   mw_d = 1'b1;
          default: a_d = res_d;
        endcase
      end
      CLS_STEP16, CLS_DAD: begin
        if (uop_i.sel[2:1] != PAIR_NONE) begin
          if (uop_i.cls == CLS_DAD) begin
            pair_d = sum17[15:0];
            cy_d   = sum17[16];
            h_d    = pair_d[15:8];
            l_d    = pair_d[7:0];
          end else begin
            pair_d = uop_i.sub ? cur16 - 16'd1 : cur16 + 16'd1;
            case (uop_i.sel[2:1])
              PAIR_BC: begin
                b_d = pair_d[15:8];
                c_d = pair_d[7:0];
              end
              PAIR_DE: begin
                d_d = pair_d[15:8];
                e_d = pair_d[7:0];
              end
              default: begin
                h_d = pair_d[15:8];
                l_d = pair_d[7:0];
              end
            endcase
          end
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
    s_d = set_szp ? res_d[7] : s_q;
    z_d = set_szp ? (res_d == 8'd0) : z_q;
    p_d = set_szp ? ~^res_d : p_q;
  end

  // State registers advance once per executed instruction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q  <= '0;
      c_q  <= '0;
      d_q  <= '0;
      e_q  <= '0;
      h_q  <= '0;
      l_q  <= '0;
      a_q  <= '0;
      cy_q <= 1'b0;
      ac_q <= 1'b0;
      s_q  <= 1'b0;
      z_q  <= 1'b0;
      p_q  <= 1'b0;
      pc_q <= '0;
    end else if (fire) begin
      b_q  <= b_d;
      c_q  <= c_d;
      d_q  <= d_d;
      e_q  <= e_d;
      h_q  <= h_d;
      l_q  <= l_d;
      a_q  <= a_d;
      cy_q <= cy_d;
      ac_q <= ac_d;
      s_q  <= s_d;
      z_q  <= z_d;
      p_q  <= p_d;
      pc_q <= pc_d;
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (uop_ready_o) begin
      valid_q <= uop_valid_i;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q  <= res_d;
      pair_q <= pair_d;
      addr_q <= hl;
      mw_q   <= mw_d;
    end
  end

  assign out_o.valid               = valid_q;
  assign out_o.result_value        = res_q;
  assign out_o.pair_value          = pair_q;
  assign out_o.memory_address      = addr_q;
  assign out_o.memory_write        = mw_q;
  assign out_o.carry_out           = cy_q;
  assign out_o.aux_carry_out       = ac_q;
  assign out_o.sign_out            = s_q;
  assign out_o.zero_out            = z_q;
  assign out_o.parity_out          = p_q;
  assign out_o.program_counter_out = pc_q;

endmodule

[src/cpu8_arithmetic_unit_core.sv]
// Top level of the 8-bit CPU arithmetic unit.
//
//   Channel  Direction  Payload
//   in_i     sink       opcode, operand_select, immediate, memory_data
//   out_o    source     result_value, pair_value, memory_address, memory_write,
//                       flags, program_counter_out
//
// One instruction per cycle sustained while out_o.ready stays high; a beat taken
// is first stored in the two-entry queue, then executes and its result is
// written to the result register, from which its result beat is offered.
// The rate is set by the execute stage, where each instruction reads and
// updates the register file and flags before the next one.
// Reset clears the general registers, the flags and the program counter at once.
// While the result register is held, the queue absorbs up to two beats, then
// in_i.ready drops.
`timescale 1ns / 1ps

module cpu8_arithmetic_unit_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  logic push_valid;
  logic push_ready;
  uop_t push_uop;
  uop_t pop_uop;
  logic pop_valid;
  logic pop_ready;

  cau_decode u_decode (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_uop_o   (push_uop)
  );

  cau_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_uop_i   (push_uop),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_uop_o    (pop_uop)
  );

  cau_execute u_execute (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (pop_valid),
    .uop_ready_o (pop_ready),
    .uop_i       (pop_uop),
    .out_o       (out_o)
  );

endmodule

[src/cau_checker.sv]
// Port-level checks of the arithmetic unit and their attachment to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  result_value_i,
  input logic [15:0] pair_value_i,
  input logic        memory_write_i,
  input logic [15:0] program_counter_i
);

  // A stalled result beat stays offered.
  `CAU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped while stalled")

  // A stalled result beat keeps its value.
  `CAU_ASSERT_PLAIN(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(result_value_i))

  // Memory write-back never comes from a pair instruction.
  `CAU_ASSERT(a_mw_pair, clk_i, rst_ni, out_valid_i && memory_write_i |-> pair_value_i == 16'd0, "memory write with pair result")

  // Pair results carry no 8-bit result.
  `CAU_ASSERT_PLAIN(a_pair_res, clk_i, rst_ni, out_valid_i && pair_value_i != 16'd0 |-> result_value_i == 8'd0)

  // Consecutive result beats carry consecutive program counters.
  `CAU_ASSERT(a_pc_step, clk_i, rst_ni, (out_valid_i && out_ready_i) ##1 out_valid_i |-> program_counter_i == $past(program_counter_i) + 16'd1, "program counter skipped")

endmodule

bind cpu8_arithmetic_unit_core cau_checker u_cau_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .result_value_i    (out_o.result_value),
  .pair_value_i      (out_o.pair_value),
  .memory_write_i    (out_o.memory_write),
  .program_counter_i (out_o.program_counter_out)
);

[tb/cau_result_checker.sv]
// Checker that executes each instruction beat in a shadow CPU and compares result beats.
`timescale 1ns / 1ps

module cau_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cau_in_if    instr_i,
  cau_out_if   result_i,
  output int   fail_count_o,
  output int   pending_o
);
  import cau_pkg::*;

  // One result beat as the shadow CPU produces it.
  typedef struct packed {
    logic [7:0]  result_value;
    logic [15:0] pair_value;
    logic [15:0] memory_address;
    logic        memory_write;
    logic        carry;
    logic        aux_carry;
    logic        sign;
    logic        zero;
    logic        parity;
    logic [15:0] program_counter;
  } instr_outcome_t;

  // Register file slot of the accumulator; B..L sit at their selector codes.
  localparam int unsigned ASlot = 6;

  // Shadow architectural state.
  logic [7:0]  shadow_regs [0:6];
  logic        flag_cy, flag_ac, flag_s, flag_z, flag_p;
  logic [15:0] shadow_pc;

  instr_outcome_t predicted_outcomes [$];
  instr_outcome_t next_outcome;
  instr_outcome_t oldest_outcome;

  function automatic int unsigned slot_of(logic [2:0] sel);
    return (sel == SEL_A) ? ASlot : int'(sel);
  endfunction

  // Returns {carry out of bit 7, carry out of bit 3, 8-bit sum}.
  function automatic logic [9:0] add_with_carries(logic [7:0] a, logic [7:0] b, logic cin);
    logic [8:0] total;
    logic [4:0] low;
    total = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    low   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    return {total[8], low[4], total[7:0]};
  endfunction

  function automatic void update_szp(logic [7:0] v);
    flag_s = v[7];
    flag_z = (v == 8'h00);
    flag_p = ~^v;
  endfunction

  // Executes one instruction on the shadow state and returns its result beat.
  task automatic execute_instruction(input logic [3:0] opc, input logic [2:0] sel,
                                     input logic [7:0] imm, input logic [7:0] mem,
                                     output instr_outcome_t outcome);
    logic [7:0]  acc, operand, value;
    logic [9:0]  sum;
    logic [8:0]  adjusted;
    logic [16:0] wide;
    logic [15:0] hl, cur, pair;
    int unsigned base;
    logic        old_cy, writes_acc, mem_write;
    hl         = {shadow_regs[SEL_H], shadow_regs[SEL_L]};
    acc        = shadow_regs[ASlot];
    old_cy     = flag_cy;
    operand    = (sel == SEL_M) ? mem : shadow_regs[slot_of(sel)];
    value      = 8'h00;
    pair       = 16'h0000;
    mem_write  = 1'b0;
    writes_acc = 1'b0;
    case (opc)
      OP_ACI, OP_ADC, OP_ADD, OP_ADI: begin
        sum = add_with_carries(acc, (opc == OP_ACI || opc == OP_ADI) ? imm : operand,
                               (opc == OP_ACI || opc == OP_ADC) && old_cy);
        flag_cy    = sum[9];
        flag_ac    = sum[8];
        value      = sum[7:0];
        writes_acc = 1'b1;
        update_szp(value);
      end
      // Subtraction adds the complement; the carry flag then holds the borrow.
      OP_SBB, OP_SBI, OP_SUB, OP_SUI: begin
        sum = add_with_carries(acc, ~((opc == OP_SBI || opc == OP_SUI) ? imm : operand),
                               !((opc == OP_SBB || opc == OP_SBI) && old_cy));
        flag_cy    = ~sum[9];
        flag_ac    = sum[8];
        value      = sum[7:0];
        writes_acc = 1'b1;
        update_szp(value);
      end
      // Decimal adjust: low nibble first, then the high nibble on the 9-bit value.
      OP_DAA: begin
        adjusted = {1'b0, acc};
        if (acc[3:0] > 4'd9 || flag_ac) begin
          flag_ac  = (acc[3:0] > 4'd9);
          adjusted = adjusted + 9'd6;
        end else begin
          flag_ac = 1'b0;
        end
        if (adjusted > 9'h09F || old_cy) begin
          adjusted = adjusted + 9'h060;
          flag_cy  = 1'b1;
        end else begin
          flag_cy = 1'b0;
        end
        value      = adjusted[7:0];
        writes_acc = 1'b1;
        update_szp(value);
      end
      // Increment and decrement leave the carry alone; M goes back to memory.
      OP_INR, OP_DCR: begin
        if (opc == OP_INR) begin
          value   = operand + 8'd1;
          flag_ac = (value[3:0] == 4'h0);
        end else begin
          value   = operand - 8'd1;
          flag_ac = (value[3:0] != 4'hF);
        end
        update_szp(value);
        if (sel == SEL_M) begin
          mem_write = 1'b1;
        end else begin
          shadow_regs[slot_of(sel)] = value;
        end
      end
      // Pair operations ignore selector bit 0; the SP/PSW slot does nothing.
      OP_DAD, OP_INX, OP_DCX: begin
        if (sel[2:1] != PAIR_NONE) begin
          base = {sel[2:1], 1'b0};
          cur  = {shadow_regs[base], shadow_regs[base + 1]};
          if (opc == OP_DAD) begin
            wide    = {1'b0, hl} + {1'b0, cur};
            flag_cy = wide[16];
            pair    = wide[15:0];
            base    = SEL_H;
          end else if (opc == OP_INX) begin
            pair = cur + 16'd1;
          end else begin
            pair = cur - 16'd1;
          end
          shadow_regs[base]     = pair[15:8];
          shadow_regs[base + 1] = pair[7:0];
        end
      end
      default: begin
      end
    endcase
    if (writes_acc) begin
      shadow_regs[ASlot] = value;
    end
    shadow_pc = shadow_pc + 16'd1;
    outcome.result_value    = value;
    outcome.pair_value      = pair;
    outcome.memory_address  = hl;
    outcome.memory_write    = mem_write;
    outcome.carry           = flag_cy;
    outcome.aux_carry       = flag_ac;
    outcome.sign            = flag_s;
    outcome.zero            = flag_z;
    outcome.parity          = flag_p;
    outcome.program_counter = shadow_pc;
  endtask

  task automatic compare_field(input string name, input logic [15:0] expected,
                               input logic [15:0] actual);
    if (actual !== expected) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, expected, actual);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  // Results are matched before new instructions are queued, so a beat that
  // leaves and one that enters in the same cycle keep their order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) begin
        shadow_regs[i] = 8'h00;
      end
      {flag_cy, flag_ac, flag_s, flag_z, flag_p} = 5'b00000;
      shadow_pc    = 16'h0000;
      fail_count_o = 0;
      predicted_outcomes.delete();
    end else begin
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        if (predicted_outcomes.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, expected none, actual 0x%0h",
                   $time, result_i.result_value);
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest_outcome = predicted_outcomes.pop_front();
          compare_field("result_value", 16'(oldest_outcome.result_value),
                        16'(result_i.result_value));
          compare_field("pair_value", oldest_outcome.pair_value, result_i.pair_value);
          compare_field("memory_address", oldest_outcome.memory_address,
                        result_i.memory_address);
          compare_field("memory_write", 16'(oldest_outcome.memory_write),
                        16'(result_i.memory_write));
          compare_field("carry_out", 16'(oldest_outcome.carry), 16'(result_i.carry_out));
          compare_field("aux_carry_out", 16'(oldest_outcome.aux_carry),
                        16'(result_i.aux_carry_out));
          compare_field("sign_out", 16'(oldest_outcome.sign), 16'(result_i.sign_out));
          compare_field("zero_out", 16'(oldest_outcome.zero), 16'(result_i.zero_out));
          compare_field("parity_out", 16'(oldest_outcome.parity), 16'(result_i.parity_out));
          compare_field("program_counter_out", oldest_outcome.program_counter,
                        result_i.program_counter_out);
        end
      end
      if (instr_i.valid === 1'b1 && instr_i.ready === 1'b1) begin
        execute_instruction(instr_i.opcode, instr_i.operand_select, instr_i.immediate,
                            instr_i.memory_data, next_outcome);
        predicted_outcomes.push_back(next_outcome);
      end
    end
    pending_o = predicted_outcomes.size();
  end

endmodule

[tb/tb_cpu8_arithmetic_unit_core.sv]
// Top of the arithmetic unit testbench: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps

module tb_cpu8_arithmetic_unit_core;
  import cau_pkg::*;

  // Opcodes outside the instruction set; the block only advances the PC.
  localparam logic [3:0] OP_RSVD_FIRST = 4'd14;
  localparam logic [3:0] OP_RSVD_LAST  = 4'd15;
  localparam int         RandomItems   = 1400;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   burst_left;
  int   gap_cycles;
  int   stall_cycle;
  int   stall_mode;

  cau_in_if  instr_if ();
  cau_out_if result_if ();

  cpu8_arithmetic_unit_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (instr_if),
    .out_o  (result_if)
  );

  cau_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .instr_i      (instr_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one instruction beat, waits for it to be taken, then maybe idles
  // at the end of a burst.
  task automatic issue_instruction(input logic [3:0] opc, input logic [2:0] sel,
                                   input logic [7:0] imm, input logic [7:0] mem);
    instr_if.valid          <= 1'b1;
    instr_if.opcode         <= opc;
    instr_if.operand_select <= sel;
    instr_if.immediate      <= imm;
    instr_if.memory_data    <= mem;
    @(posedge clk);
    while (instr_if.ready !== 1'b1) begin
      @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_cycles > 0) begin
        instr_if.valid <= 1'b0;
        repeat (gap_cycles) @(posedge clk);
      end
    end
  endtask

  // Data bytes lean toward the values that stress carries and decimal adjust.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'h99;
      4:       return 8'h9F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // The result side cycles through ready patterns so stalls hit every phase.
  initial begin
    result_if.ready <= 1'b0;
    stall_cycle = 0;
    stall_mode  = 0;
    forever begin
      @(posedge clk);
      stall_cycle++;
      if (stall_cycle % 48 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= ($urandom_range(0, 3) != 0);
        2:       result_if.ready <= ((stall_cycle % 7) < 4);
        default: result_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Reset, directed instructions, random instructions, drain and verdict.
  initial begin
    logic [3:0] opc;
    rst_n                   <= 1'b0;
    instr_if.valid          <= 1'b0;
    instr_if.opcode         <= OP_ACI;
    instr_if.operand_select <= SEL_B;
    instr_if.immediate      <= 8'h00;
    instr_if.memory_data    <= 8'h00;
    burst_left = 8;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Add and subtract extremes with carry and borrow in and out.
    issue_instruction(OP_ADI, SEL_B, 8'hFF, 8'h00);
    issue_instruction(OP_ACI, SEL_C, 8'h01, 8'h00);
    issue_instruction(OP_ACI, SEL_D, 8'h00, 8'h00);
    issue_instruction(OP_SUI, SEL_E, 8'h02, 8'h00);
    issue_instruction(OP_SBI, SEL_H, 8'h00, 8'h00);
    // Register and memory increment and decrement across nibble wraps.
    issue_instruction(OP_INR, SEL_B, 8'h00, 8'h00);
    issue_instruction(OP_DCR, SEL_C, 8'h00, 8'h00);
    issue_instruction(OP_INR, SEL_M, 8'h00, 8'hFF);
    issue_instruction(OP_DCR, SEL_M, 8'h00, 8'h00);
    // Pair steps, odd selectors, double add with carry, and the unused pair slot.
    issue_instruction(OP_INX, SEL_L, 8'h00, 8'h00);
    issue_instruction(OP_DCX, SEL_D, 8'h00, 8'h00);
    issue_instruction(OP_DAD, SEL_B, 8'h00, 8'h00);
    issue_instruction(OP_DAD, SEL_E, 8'h00, 8'h00);
    issue_instruction(OP_DAD, SEL_M, 8'h00, 8'h00);
    issue_instruction(OP_INX, SEL_A, 8'h00, 8'h00);
    // Register, memory and accumulator operands.
    issue_instruction(OP_ADD, SEL_A, 8'h00, 8'h00);
    issue_instruction(OP_ADC, SEL_M, 8'h00, 8'h80);
    issue_instruction(OP_SUB, SEL_M, 8'h00, 8'hFF);
    issue_instruction(OP_SBB, SEL_A, 8'h00, 8'h00);
    // Decimal adjust with both nibbles corrected, then with a wrap to zero.
    issue_instruction(OP_SUB, SEL_A, 8'h00, 8'h00);
    issue_instruction(OP_ADI, SEL_B, 8'h9B, 8'h00);
    issue_instruction(OP_DAA, SEL_B, 8'h00, 8'h00);
    issue_instruction(OP_ADI, SEL_B, 8'h99, 8'h00);
    issue_instruction(OP_DAA, SEL_B, 8'h00, 8'h00);
    // Opcodes outside the instruction set.
    issue_instruction(OP_RSVD_FIRST, SEL_A, 8'hFF, 8'hFF);
    issue_instruction(OP_RSVD_LAST, SEL_M, 8'h00, 8'h00);

    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        opc = 4'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      end else begin
        opc = 4'($urandom_range(OP_ACI, OP_SUI));
      end
      issue_instruction(opc, 3'($urandom_range(0, 7)), pick_byte(), pick_byte());
    end
    instr_if.valid <= 1'b0;

    // Let the checker record the last accepted beat before draining.
    @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/cau_pkg.sv
src/cau_if.sv
src/cau_decode.sv
src/cau_queue.sv
src/cau_execute.sv
src/cpu8_arithmetic_unit_core.sv
src/cau_checker.sv
tb/cau_result_checker.sv
tb/tb_cpu8_arithmetic_unit_core.sv
